FILE: src/business_day_counter_defines.svh
// ----------------------------------------------------------------------------
// business day counter assertion macros
// shared helpers for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef BUSINESS_DAY_COUNTER_DEFINES_SVH
`define BUSINESS_DAY_COUNTER_DEFINES_SVH

// check sampled on the rising clock, off while reset is low
`define BDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// check sampled on the rising clock, also while reset is low
`define BDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// types, constants and calendar tables shared by the business day counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdc_pkg;

  // field widths
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned COUNT_W     = 22;
  localparam int unsigned WDAY_W      = 3;
  localparam int unsigned MASK_W      = 7;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // register map
  localparam logic REG_WEEKEND_MASK = 1'b0;
  localparam logic [MASK_W-1:0] WEEKEND_MASK_RESET = 7'd96;

  // calendar constants
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
  localparam logic [6:0]         YEARS_CENT  = 7'd100;
  localparam logic [8:0]         YEARS_ERA   = 9'd400;
  localparam logic [8:0]         DAYS_YEAR   = 9'd365;
  localparam logic [17:0]        DAYS_ERA    = 18'd146097;
  localparam logic [2:0]         DAYS_WEEK   = 3'd7;
  localparam logic [1:0]         WDAY_BIAS   = 2'd3;

  // reciprocals for division by constants
  localparam logic [13:0] RECIP_100     = 14'd10486;   // shift 20
  localparam logic [12:0] RECIP_400     = 13'd5243;    // shift 21
  localparam logic [5:0]  RECIP_100_YOE = 6'd41;       // shift 12
  localparam logic [19:0] RECIP_7       = 20'd599186;  // shift 22

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LOAD = 4'd1,
    OP_Y100 = 4'd2,
    OP_ERA  = 4'd3,
    OP_YOE  = 4'd4,
    OP_DOE  = 4'd5,
    OP_DNUM = 4'd6,
    OP_MMUL = 4'd7,
    OP_MFIX = 4'd8,
    OP_TOT  = 4'd9,
    OP_BIZ  = 4'd10
  } dp_op_e;

  // which value the shared units work on
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_END   = 2'd1,
    PH_TOTAL = 2'd2
  } phase_e;

  typedef struct packed {
    dp_op_e op;
    phase_e phase;
  } dp_cmd_t;

  // month length, zero for a month code outside the year
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days from march 1 to the first of the month
  function automatic logic [8:0] march_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

FILE: src/business_day_counter.sv
// ----------------------------------------------------------------------------
// business_day_counter
// counts all days and working days between two gregorian dates
// ----------------------------------------------------------------------------
// One request carries a start date and an end date; the result gives the
// number of days from the start (included) to the end (excluded), how many of
// those fall outside the weekend mask, the weekday of both dates and an error
// flag for an impossible date, which zeroes the other fields. The time to a
// result does not depend on the date range, only on the final step waiting
// for a free output register; a request is finished before the next is taken:
// both dates run one after the other through the same five-step day-number
// sequence, and one shared two-step mod 7 unit splits each day number and the
// day count. A new request is taken as soon as the sequencer is back in idle,
// even while the previous result waits on the output. The weekend mask
// (bit 0 Sunday .. bit 6 Saturday, reset Friday and Saturday) is written over
// APB at byte address 0 and must only change while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module business_day_counter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // start_day, start_month, start_year, end_day, end_month, end_year
  input  logic [bdc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // business_days, total_days, start_weekday, end_weekday, date_error
  output logic [bdc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bdc_pkg::ADDR_W-1:0]       paddr,
  input  logic [bdc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bdc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic [bdc_pkg::MASK_W-1:0] weekend_mask_q, weekend_mask_d;
  logic                       mask_sel, mask_wr;
  bdc_pkg::dp_cmd_t           cmd;

  // configuration register
  assign pready   = 1'b1;
  assign mask_sel = (paddr[2] == bdc_pkg::REG_WEEKEND_MASK);
  assign mask_wr  = psel && penable && pwrite && pready && mask_sel;
  assign weekend_mask_d = mask_wr ? pwdata[bdc_pkg::MASK_W-1:0] : weekend_mask_q;
  assign prdata   = mask_sel ? {25'd0, weekend_mask_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weekend_mask_q <= bdc_pkg::WEEKEND_MASK_RESET;
    end else begin
      weekend_mask_q <= weekend_mask_d;
    end
  end

  // sequencer
  bdc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  // arithmetic
  bdc_datapath u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .in_data_i      (s_axis_tdata),
    .weekend_mask_i (weekend_mask_q),
    .out_data_o     (m_axis_tdata)
  );

endmodule

FILE: src/bdc_ctrl.sv
// ----------------------------------------------------------------------------
// bdc_ctrl
// sequencer that steps the datapath through both day numbers, the weekday
// and week splits and the final count, and owns the request handshakes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output bdc_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_Y100 = 10'b0000000010,
    ST_ERA  = 10'b0000000100,
    ST_YOE  = 10'b0000001000,
    ST_DOE  = 10'b0000010000,
    ST_DNUM = 10'b0000100000,
    ST_MMUL = 10'b0001000000,
    ST_MFIX = 10'b0010000000,
    ST_TOT  = 10'b0100000000,
    ST_BIZ  = 10'b1000000000
  } ctrl_state_e;

  ctrl_state_e      state_q, state_d;
  bdc_pkg::phase_e  phase_q, phase_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

  // next state and command decode
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = bdc_pkg::OP_NONE;
    cmd_o.phase = phase_q;
    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = bdc_pkg::OP_LOAD;
          phase_d  = bdc_pkg::PH_START;
          state_d  = ST_Y100;
        end
      end
      ST_Y100: begin
        cmd_o.op = bdc_pkg::OP_Y100;
        state_d  = ST_ERA;
      end
      ST_ERA: begin
        cmd_o.op = bdc_pkg::OP_ERA;
        state_d  = ST_YOE;
      end
      ST_YOE: begin
        cmd_o.op = bdc_pkg::OP_YOE;
        state_d  = ST_DOE;
      end
      ST_DOE: begin
        cmd_o.op = bdc_pkg::OP_DOE;
        state_d  = ST_DNUM;
      end
      ST_DNUM: begin
        cmd_o.op = bdc_pkg::OP_DNUM;
        state_d  = ST_MMUL;
      end
      ST_MMUL: begin
        cmd_o.op = bdc_pkg::OP_MMUL;
        state_d  = ST_MFIX;
      end
      ST_MFIX: begin
        cmd_o.op = bdc_pkg::OP_MFIX;
        unique case (phase_q)
          bdc_pkg::PH_START: begin
            phase_d = bdc_pkg::PH_END;
            state_d = ST_Y100;
          end
          bdc_pkg::PH_END: begin
            state_d = ST_TOT;
          end
          default: begin
            state_d = ST_BIZ;
          end
        endcase
      end
      ST_TOT: begin
        cmd_o.op = bdc_pkg::OP_TOT;
        phase_d  = bdc_pkg::PH_TOTAL;
        state_d  = ST_MMUL;
      end
      ST_BIZ: begin
        // hold the finished item until the output register is free
        if (slot_free) begin
          cmd_o.op    = bdc_pkg::OP_BIZ;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= bdc_pkg::PH_START;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/bdc_datapath.sv
// ----------------------------------------------------------------------------
// bdc_datapath
// date check, day number arithmetic, shared mod 7 unit, week count and the
// output register of the business day counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdc_datapath (
  input  logic                               clk_i,
  input  bdc_pkg::dp_cmd_t                   cmd_i,
  input  logic [bdc_pkg::IN_TDATA_W-1:0]     in_data_i,
  input  logic [bdc_pkg::MASK_W-1:0]         weekend_mask_i,
  output logic [bdc_pkg::OUT_TDATA_W-1:0]    out_data_o
);

  // captured request
  logic [bdc_pkg::DAY_W-1:0]   sd_q, ed_q;
  logic [bdc_pkg::MONTH_W-1:0] sm_q, em_q;
  logic [bdc_pkg::YEAR_W-1:0]  sy_q, ey_q;

  // working registers
  logic [bdc_pkg::YEAR_W-1:0]  yy_q;
  logic [7:0]                  y100_q;
  logic [5:0]                  era_q;
  logic [8:0]                  yoe_q;
  logic [8:0]                  doy_q;
  logic [17:0]                 doe_q;
  logic [bdc_pkg::COUNT_W-1:0] ns_q, ne_q, total_q, mod_x_q;
  logic [19:0]                 mod_q_q, tq_q;
  logic [bdc_pkg::WDAY_W-1:0]  ws_q, we_q, trem_q;
  logic                        err_q;
  logic [bdc_pkg::OUT_TDATA_W-1:0] out_q;

  // current date
  logic [bdc_pkg::DAY_W-1:0]   cur_d;
  logic [bdc_pkg::MONTH_W-1:0] cur_m;
  logic [bdc_pkg::YEAR_W-1:0]  cur_y;
  logic                        sel_end;

  assign sel_end = (cmd_i.phase == bdc_pkg::PH_END);
  assign cur_d   = sel_end ? ed_q : sd_q;
  assign cur_m   = sel_end ? em_q : sm_q;
  assign cur_y   = sel_end ? ey_q : sy_q;

  // year / 100 and march-based year
  logic [27:0]                y100_prod;
  logic [bdc_pkg::YEAR_W-1:0] yy_d;
  assign y100_prod = cur_y * bdc_pkg::RECIP_100;
  assign yy_d      = (cur_m <= bdc_pkg::MONTH_FEB) ? (cur_y - 14'd1) : cur_y;

  // era and date check
  logic [26:0]                era_prod;
  logic [14:0]                cent_prod;
  logic [bdc_pkg::YEAR_W-1:0] r100;
  logic                       leap, date_ok;
  logic [bdc_pkg::DAY_W-1:0]  mlen;
  assign era_prod  = yy_q * bdc_pkg::RECIP_400;
  assign cent_prod = y100_q * bdc_pkg::YEARS_CENT;
  assign r100      = cur_y - cent_prod[bdc_pkg::YEAR_W-1:0];
  assign leap      = ((cur_y[1:0] == 2'd0) && (r100 != '0)) ||
                     ((r100 == '0) && (y100_q[1:0] == 2'd0));
  assign mlen      = bdc_pkg::month_len(cur_m, leap);
  assign date_ok   = (cur_m >= 4'd1) && (cur_m <= bdc_pkg::MONTH_DEC) &&
                     (cur_y >= 14'd1) && (cur_y <= bdc_pkg::YEAR_MAX) &&
                     (cur_d >= 5'd1) && (cur_d <= mlen);

  // year of era and day of year
  logic [14:0] era_years, yoe_diff;
  assign era_years = era_q * bdc_pkg::YEARS_ERA;
  assign yoe_diff  = {1'b0, yy_q} - era_years;

  // day of era
  logic [14:0] yoe100_prod;
  logic [17:0] yoe_days, doe_d;
  assign yoe100_prod = yoe_q * bdc_pkg::RECIP_100_YOE;
  assign yoe_days    = yoe_q * bdc_pkg::DAYS_YEAR;
  assign doe_d       = yoe_days + 18'(yoe_q[8:2]) - 18'(yoe100_prod[14:12]) + 18'(doy_q);

  // day number
  logic [23:0] dnum_sum;
  assign dnum_sum = (era_q * bdc_pkg::DAYS_ERA) + {6'd0, doe_q};

  // shared mod 7 unit, reciprocal step then one correction
  logic [bdc_pkg::COUNT_W-1:0] mod_src;
  logic [41:0]                 mod_prod;
  logic [22:0]                 mod_back;
  logic [3:0]                  mod_r;
  logic [2:0]                  mod_rem;
  logic [19:0]                 mod_quo;
  always_comb begin
    case (cmd_i.phase)
      bdc_pkg::PH_START: mod_src = ns_q + 22'(bdc_pkg::WDAY_BIAS);
      bdc_pkg::PH_END:   mod_src = ne_q + 22'(bdc_pkg::WDAY_BIAS);
      default:           mod_src = total_q;
    endcase
  end
  assign mod_prod = mod_src * bdc_pkg::RECIP_7;
  assign mod_back = mod_q_q * bdc_pkg::DAYS_WEEK;
  assign mod_r    = mod_x_q[3:0] - mod_back[3:0];
  always_comb begin
    if (mod_r >= 4'(bdc_pkg::DAYS_WEEK)) begin
      mod_rem = 3'(mod_r - 4'(bdc_pkg::DAYS_WEEK));
      mod_quo = mod_q_q + 20'd1;
    end else begin
      mod_rem = mod_r[2:0];
      mod_quo = mod_q_q;
    end
  end

  // business days from whole weeks and the leftover days
  logic [2:0]  work_per_week, rem_work;
  logic [3:0]  wd_sum;
  logic [2:0]  wd_idx;
  logic [22:0] week_days;
  logic [bdc_pkg::COUNT_W-1:0] biz;
  always_comb begin
    work_per_week = 3'd0;
    for (int k = 0; k < bdc_pkg::MASK_W; k++) begin
      work_per_week = work_per_week + 3'(!weekend_mask_i[k]);
    end
    rem_work = 3'd0;
    for (int k = 0; k < bdc_pkg::MASK_W - 1; k++) begin
      wd_sum = 4'(ws_q) + 4'(k);
      if (wd_sum >= 4'(bdc_pkg::DAYS_WEEK)) begin
        wd_sum = wd_sum - 4'(bdc_pkg::DAYS_WEEK);
      end
      wd_idx = wd_sum[2:0];
      if ((3'(k) < trem_q) && !weekend_mask_i[wd_idx]) begin
        rem_work = rem_work + 3'd1;
      end
    end
  end
  assign week_days = tq_q * work_per_week;
  assign biz       = week_days[bdc_pkg::COUNT_W-1:0] + 22'(rem_work);

  // register updates per command
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      bdc_pkg::OP_LOAD: begin
        sd_q  <= in_data_i[4:0];
        sm_q  <= in_data_i[8:5];
        sy_q  <= in_data_i[22:9];
        ed_q  <= in_data_i[27:23];
        em_q  <= in_data_i[31:28];
        ey_q  <= in_data_i[45:32];
        err_q <= 1'b0;
      end
      bdc_pkg::OP_Y100: begin
        y100_q <= y100_prod[27:20];
        yy_q   <= yy_d;
      end
      bdc_pkg::OP_ERA: begin
        era_q <= era_prod[26:21];
        err_q <= err_q | !date_ok;
      end
      bdc_pkg::OP_YOE: begin
        yoe_q <= yoe_diff[8:0];
        doy_q <= bdc_pkg::march_offset(cur_m) + 9'(cur_d) - 9'd1;
      end
      bdc_pkg::OP_DOE: begin
        doe_q <= doe_d;
      end
      bdc_pkg::OP_DNUM: begin
        if (sel_end) begin
          ne_q <= dnum_sum[bdc_pkg::COUNT_W-1:0];
        end else begin
          ns_q <= dnum_sum[bdc_pkg::COUNT_W-1:0];
        end
      end
      bdc_pkg::OP_MMUL: begin
        mod_x_q <= mod_src;
        mod_q_q <= mod_prod[41:22];
      end
      bdc_pkg::OP_MFIX: begin
        case (cmd_i.phase)
          bdc_pkg::PH_START: ws_q <= mod_rem;
          bdc_pkg::PH_END:   we_q <= mod_rem;
          default: begin
            tq_q   <= mod_quo;
            trem_q <= mod_rem;
          end
        endcase
      end
      bdc_pkg::OP_TOT: begin
        total_q <= (ns_q < ne_q) ? (ne_q - ns_q) : '0;
      end
      bdc_pkg::OP_BIZ: begin
        // packed result: biz, total, start weekday, end weekday, error
        if (err_q) begin
          out_q <= {5'd0, 1'b1, 50'd0};
        end else begin
          out_q <= {5'd0, 1'b0, we_q, ws_q, total_q, biz};
        end
      end
      default: ;
    endcase
  end

  assign out_data_o = out_q;

endmodule

FILE: src/bdc_checker.sv
// ----------------------------------------------------------------------------
// bdc_checker
// port-level checks on the result stream of the business day counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "business_day_counter_defines.svh"

module bdc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bdc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // a pending result is never withdrawn
  `BDC_ASSERT(a_valid_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

  // no result once reset has been seen at an edge
  `BDC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "result valid in reset")

  // an impossible date zeroes counts and weekdays
  `BDC_ASSERT(a_err_zero, m_axis_tvalid && m_axis_tdata[50] |-> m_axis_tdata[49:0] == '0, "error result not zero")

  // working days never exceed all days
  `BDC_ASSERT(a_biz_le_total, m_axis_tvalid |-> m_axis_tdata[21:0] <= m_axis_tdata[43:22], "business days above total")

  // weekdays stay in Sunday .. Saturday
  `BDC_ASSERT(a_wday_range, m_axis_tvalid |-> m_axis_tdata[46:44] != 3'd7 && m_axis_tdata[49:47] != 3'd7, "weekday out of range")

endmodule

bind business_day_counter bdc_checker u_bdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
